// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the blob track matcher.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define BTM_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// Condition that must hold in the cycle after a trigger.
`define BTM_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// File: sv/btm_pkg.sv
// ----------------------------------------------------------------------------
// btm_pkg
// Types, sizes and codes shared by the blob track matcher.
// ----------------------------------------------------------------------------
package btm_pkg;

  localparam int MAX_TRACKS = 64;
  localparam int MAX_FB     = 32;
  localparam int COORD_W    = 10;
  localparam int TRK_IDX_W  = $clog2(MAX_TRACKS);
  localparam int TRK_CNT_W  = $clog2(MAX_TRACKS + 1);
  localparam int STEP_W     = $clog2(MAX_TRACKS + 2);
  localparam int FB_IDX_W   = (MAX_FB > 1) ? $clog2(MAX_FB) : 1;
  localparam int FB_CNT_W   = $clog2(MAX_FB + 1);
  localparam int DIST_W     = 2 * COORD_W;
  localparam int SUM_W      = DIST_W + 1;
  localparam int REG_W      = 10;
  localparam int CFG_IDX_W  = 3;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_AGE   = 2'd1;
  localparam logic [1:0] CMD_EMPTY = 2'd2;

  localparam logic [2:0] ST_DROP  = 3'd0;
  localparam logic [2:0] ST_MATCH = 3'd1;
  localparam logic [2:0] ST_NEW   = 3'd2;
  localparam logic [2:0] ST_FULL  = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_TOL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MINX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MINY = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAXX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAXY = 3'd4;

  typedef logic [2:0] bc_op_t;
  localparam bc_op_t BC_NONE   = 3'd0;
  localparam bc_op_t BC_FRAME  = 3'd1;
  localparam bc_op_t BC_AGE    = 3'd2;
  localparam bc_op_t BC_SEEN   = 3'd3;
  localparam bc_op_t BC_MATCH  = 3'd4;
  localparam bc_op_t BC_CREATE = 3'd5;

  typedef struct packed {
    logic [COORD_W-1:0] first_x;
    logic [COORD_W-1:0] first_y;
    logic [COORD_W-1:0] recent_x;
    logic [COORD_W-1:0] recent_y;
    logic               hist;
    logic               active;
    logic               seen;
    logic [DIST_W-1:0]  best;
  } trk_t;

  typedef struct packed {
    bc_op_t               op;
    logic [TRK_IDX_W-1:0] idx;
    logic [COORD_W-1:0]   cx;
    logic [COORD_W-1:0]   cy;
    logic [DIST_W-1:0]    tol2;
  } bcast_t;

  typedef struct packed {
    logic                 has_cand;
    logic                 visible;
    logic [TRK_IDX_W-1:0] cand;
  } scan_res_t;

endpackage

// File: sv/btm_cell.sv
// ----------------------------------------------------------------------------
// btm_cell
// One track slot of the ring: shifts to its neighbor or applies a broadcast.
// ----------------------------------------------------------------------------
module btm_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [btm_pkg::TRK_IDX_W-1:0]   cell_idx,
  input  logic                            shift,
  input  btm_pkg::trk_t                   rec_in,
  input  btm_pkg::bcast_t                 bc,
  output btm_pkg::trk_t                   rec
);
  import btm_pkg::*;

  logic hit;
  assign hit = (bc.idx == cell_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      rec.hist   <= 1'b0;
      rec.active <= 1'b0;
      rec.seen   <= 1'b0;
    end else if (shift) begin
      rec <= rec_in;
    end else begin
      case (bc.op)
        BC_FRAME: begin
          rec.best <= bc.tol2;
          rec.seen <= 1'b0;
        end
        BC_AGE:   rec.active <= rec.active & rec.seen;
        BC_SEEN:  if (hit) rec.seen <= 1'b1;
        BC_MATCH: begin
          if (hit) begin
            rec.recent_x <= bc.cx;
            rec.recent_y <= bc.cy;
            rec.hist     <= 1'b1;
          end
        end
        BC_CREATE: begin
          if (hit) begin
            rec.first_x  <= bc.cx;
            rec.first_y  <= bc.cy;
            rec.recent_x <= '0;
            rec.recent_y <= '0;
            rec.best     <= bc.tol2;
            rec.hist     <= 1'b0;
            rec.active   <= 1'b1;
            rec.seen     <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: sv/btm_dist.sv
// ----------------------------------------------------------------------------
// btm_dist
// Distance stages at the head of the ring and the per-blob running search.
// ----------------------------------------------------------------------------
module btm_dist (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            shift,
  input  logic                            start,
  input  logic                            eval,
  input  logic [btm_pkg::TRK_IDX_W-1:0]   idx,
  input  logic [btm_pkg::COORD_W-1:0]     cx,
  input  logic [btm_pkg::COORD_W-1:0]     cy,
  input  logic [btm_pkg::DIST_W-1:0]      tol2,
  input  btm_pkg::trk_t                   rec_in,
  output btm_pkg::trk_t                   rec_out,
  output btm_pkg::scan_res_t              res
);
  import btm_pkg::*;

  trk_t               p1_rec;
  trk_t               p2_rec;
  logic [COORD_W-1:0] adx_f, ady_f, adx_r, ady_r;
  logic [SUM_W-1:0]   d_f, d_r;
  logic [DIST_W-1:0]  sq_xf, sq_yf, sq_xr, sq_yr;
  logic [SUM_W-1:0]   d_sel;
  logic               in_tol, not_worse, better, hit;
  logic [DIST_W-1:0]  run_best;

  function automatic logic [COORD_W-1:0] absdiff(input logic [COORD_W-1:0] a,
                                                 input logic [COORD_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_ff @(posedge clk) begin
    if (shift) begin
      p1_rec <= rec_in;
      adx_f  <= absdiff(cx, rec_in.first_x);
      ady_f  <= absdiff(cy, rec_in.first_y);
      adx_r  <= absdiff(cx, rec_in.recent_x);
      ady_r  <= absdiff(cy, rec_in.recent_y);
      p2_rec <= p1_rec;
      d_f    <= {1'b0, sq_xf} + {1'b0, sq_yf};
      d_r    <= {1'b0, sq_xr} + {1'b0, sq_yr};
    end
  end

  assign sq_xf = DIST_W'(adx_f) * DIST_W'(adx_f);
  assign sq_yf = DIST_W'(ady_f) * DIST_W'(ady_f);
  assign sq_xr = DIST_W'(adx_r) * DIST_W'(adx_r);
  assign sq_yr = DIST_W'(ady_r) * DIST_W'(ady_r);

  always_comb begin
    d_sel     = (p2_rec.hist && (d_r < d_f)) ? d_r : d_f;
    in_tol    = (d_sel <= {1'b0, tol2});
    not_worse = (d_sel <= {1'b0, p2_rec.best});
    better    = ({1'b0, run_best} > d_sel);
    hit       = eval && p2_rec.active && in_tol;
    rec_out   = p2_rec;
    if (hit && not_worse && better) begin
      rec_out.best = d_sel[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.has_cand <= 1'b0;
      res.visible  <= 1'b1;
    end else if (start) begin
      res.has_cand <= 1'b0;
      res.visible  <= 1'b1;
      run_best     <= tol2;
    end else if (shift && hit) begin
      if (!not_worse) begin
        res.visible <= 1'b0;
      end else if (better) begin
        res.has_cand <= 1'b1;
        run_best     <= d_sel[DIST_W-1:0];
        res.cand     <= idx;
      end
    end
  end

endmodule

// File: sv/blob_track_matcher.sv
// ----------------------------------------------------------------------------
// blob_track_matcher
// Frame-based blob to track matcher over a ring of track cells.
// ----------------------------------------------------------------------------
// Usage: boxes of a frame arrive on the input channel (command load), one per
// transfer; up to 32 are stored, the rest ignored. The box flagged
// last_in_frame starts matching. Each stored blob is scanned against all
// tracks as the 64 track cells and two distance stages rotate past one
// distance unit: per blob a load state, the ring steps of the scan state and
// a seen-update state, after a frame-start state for the frame.
// Then one result per blob goes out, each through a read state and an emit
// state. The input stays not ready from the last box until the
// frame's last result transfer.
// Age and empty commands act when accepted; empty frame yields one result.
// A stalled receiver holds the output register and blocks the next result
// and new input transfers. Configuration writes are taken every cycle.
// Reset clears the track table flags, counters and registers to defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blob_track_matcher (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      command,
  input  logic [btm_pkg::COORD_W-1:0]     min_x,
  input  logic [btm_pkg::COORD_W-1:0]     min_y,
  input  logic [btm_pkg::COORD_W-1:0]     max_x,
  input  logic [btm_pkg::COORD_W-1:0]     max_y,
  input  logic                            last_in_frame,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      status,
  output logic [btm_pkg::TRK_IDX_W-1:0]   track_index,
  output logic                            in_roi,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [btm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [btm_pkg::REG_W-1:0]       cfg_data
);
  import btm_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_FSTART = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_SEEN   = 3'd4;
  localparam logic [2:0] S_RLOAD  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  logic [2:0]           state;
  logic [REG_W-1:0]     match_tolerance, roi_min_x, roi_min_y, roi_max_x, roi_max_y;
  logic [DIST_W-1:0]    tol2;
  logic [FB_CNT_W-1:0]  blob_total;
  logic [TRK_CNT_W-1:0] track_total;
  logic [FB_IDX_W-1:0]  j;
  logic [STEP_W-1:0]    step;
  logic                 in_fire, emit_go, last_blob, scan_end, out_load;

  logic [COORD_W-1:0]   cx_mem [MAX_FB];
  logic [COORD_W-1:0]   cy_mem [MAX_FB];
  logic                 roi_mem [MAX_FB];
  scan_res_t            res_mem [MAX_FB];
  logic [COORD_W-1:0]   cx_rd, cy_rd;
  logic                 roi_rd;
  scan_res_t            res_rd;

  logic [COORD_W:0]     sum_x, sum_y;
  logic                 apart;

  trk_t                 cell_rec [MAX_TRACKS];
  trk_t                 ring_in  [MAX_TRACKS];
  trk_t                 dist_out;
  scan_res_t            scan_res;
  bcast_t               bc;
  logic                 shift;

  logic [2:0]           status_next;
  logic [TRK_IDX_W-1:0] idx_next;
  logic                 roi_next, last_next;

  assign cfg_ready = 1'b1;
  assign tol2      = DIST_W'(match_tolerance) * DIST_W'(match_tolerance);
  assign in_ready  = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign emit_go   = (state == S_EMIT) && (!out_valid || out_ready);
  assign last_blob = (FB_CNT_W'(j) + FB_CNT_W'(1)) == blob_total;
  assign scan_end  = (step == STEP_W'(MAX_TRACKS + 1));
  assign shift     = (state == S_SCAN);
  assign out_load  = emit_go || (in_fire && command == CMD_EMPTY);

  assign sum_x = {1'b0, min_x} + {1'b0, max_x};
  assign sum_y = {1'b0, min_y} + {1'b0, max_y};
  assign apart = (min_x > roi_max_x) || (roi_min_x > max_x) ||
                 (min_y > roi_max_y) || (roi_min_y > max_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      match_tolerance <= REG_W'(50);
      roi_min_x       <= '0;
      roi_min_y       <= '0;
      roi_max_x       <= REG_W'(1023);
      roi_max_y       <= REG_W'(1023);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TOL:  match_tolerance <= cfg_data;
        REG_MINX: roi_min_x <= cfg_data;
        REG_MINY: roi_min_y <= cfg_data;
        REG_MAXX: roi_max_x <= cfg_data;
        REG_MAXY: roi_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // blob store and per-blob search results
  always_ff @(posedge clk) begin
    if (in_fire && command == CMD_LOAD && blob_total < FB_CNT_W'(MAX_FB)) begin
      cx_mem[blob_total[FB_IDX_W-1:0]]  <= sum_x[COORD_W:1];
      cy_mem[blob_total[FB_IDX_W-1:0]]  <= sum_y[COORD_W:1];
      roi_mem[blob_total[FB_IDX_W-1:0]] <= !apart;
    end
    if (state == S_SEEN) begin
      res_mem[j] <= scan_res;
    end
    cx_rd  <= cx_mem[j];
    cy_rd  <= cy_mem[j];
    roi_rd <= roi_mem[j];
    res_rd <= res_mem[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      blob_total  <= '0;
      track_total <= '0;
      j           <= '0;
      step        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (command)
              CMD_LOAD: begin
                if (blob_total < FB_CNT_W'(MAX_FB)) blob_total <= blob_total + FB_CNT_W'(1);
                if (last_in_frame) state <= S_FSTART;
              end
              CMD_EMPTY: blob_total <= '0;
              default: ;
            endcase
          end
        end
        S_FSTART: begin
          j     <= '0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          step  <= '0;
          state <= S_SCAN;
        end
        S_SCAN: begin
          step <= step + STEP_W'(1);
          if (scan_end) state <= S_SEEN;
        end
        S_SEEN: begin
          if (last_blob) begin
            j     <= '0;
            state <= S_RLOAD;
          end else begin
            j     <= j + FB_IDX_W'(1);
            state <= S_LOAD;
          end
        end
        S_RLOAD: state <= S_EMIT;
        S_EMIT: begin
          if (emit_go) begin
            if (bc.op == BC_CREATE) track_total <= track_total + TRK_CNT_W'(1);
            if (last_blob) begin
              blob_total <= '0;
              state      <= S_IDLE;
            end else begin
              j     <= j + FB_IDX_W'(1);
              state <= S_RLOAD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    bc.op   = BC_NONE;
    bc.idx  = '0;
    bc.cx   = cx_rd;
    bc.cy   = cy_rd;
    bc.tol2 = tol2;
    status_next = ST_EMPTY;
    idx_next    = '0;
    roi_next    = 1'b0;
    last_next   = 1'b1;
    case (state)
      S_IDLE: begin
        if (in_fire && command == CMD_AGE)   bc.op = BC_AGE;
        if (in_fire && command == CMD_EMPTY) bc.op = BC_FRAME;
      end
      S_FSTART: bc.op = BC_FRAME;
      S_SEEN: begin
        if (scan_res.has_cand) begin
          bc.op  = BC_SEEN;
          bc.idx = scan_res.cand;
        end
      end
      S_EMIT: begin
        roi_next  = roi_rd;
        last_next = last_blob;
        if (!res_rd.visible) begin
          status_next = ST_DROP;
        end else if (res_rd.has_cand) begin
          status_next = ST_MATCH;
          idx_next    = res_rd.cand;
          bc.idx      = res_rd.cand;
          if (emit_go) bc.op = BC_MATCH;
        end else if (track_total < TRK_CNT_W'(MAX_TRACKS)) begin
          status_next = ST_NEW;
          idx_next    = track_total[TRK_IDX_W-1:0];
          bc.idx      = track_total[TRK_IDX_W-1:0];
          if (emit_go) bc.op = BC_CREATE;
        end else begin
          status_next = ST_FULL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= status_next;
      track_index <= idx_next;
      in_roi      <= roi_next;
      last        <= last_next;
    end
  end

  // track ring: cell 0 feeds the distance unit, which refills the far end
  genvar k;
  generate
    for (k = 0; k < MAX_TRACKS; k++) begin : g_cell
      if (k < MAX_TRACKS - 1) begin : g_mid
        assign ring_in[k] = cell_rec[k+1];
      end else begin : g_end
        assign ring_in[k] = dist_out;
      end
      btm_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_idx (TRK_IDX_W'(k)),
        .shift    (shift),
        .rec_in   (ring_in[k]),
        .bc       (bc),
        .rec      (cell_rec[k])
      );
    end
  endgenerate

  btm_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .shift   (shift),
    .start   (state == S_LOAD),
    .eval    (shift && step >= STEP_W'(2)),
    .idx     (TRK_IDX_W'(step - STEP_W'(2))),
    .cx      (cx_rd),
    .cy      (cy_rd),
    .tol2    (tol2),
    .rec_in  (cell_rec[0]),
    .rec_out (dist_out),
    .res     (scan_res)
  );

  `BTM_ASSERT(a_track_total_max, track_total <= TRK_CNT_W'(MAX_TRACKS))
  `BTM_ASSERT(a_blob_total_max, blob_total <= FB_CNT_W'(MAX_FB))
  `BTM_ASSERT(a_scan_step, !shift || step <= STEP_W'(MAX_TRACKS + 1))
  `BTM_ASSERT_NEXT(a_emit_done, emit_go && last_blob, state == S_IDLE && out_valid && last)

endmodule

// File: tb/blob_track_matcher_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// blob_track_matcher_tb
// Self-checking bench for the blob track matcher: a directed table of boxes
// and commands, directed region and tolerance cases, then random frames, each
// transfer predicted by a behavioral copy of the track table and compared field by field with the DUT output.
// ----------------------------------------------------------------------------
module blob_track_matcher_tb;
  import btm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] cmd;
    logic [9:0] mnx, mny, mxx, mxy;
    logic       lif;
  } box_t;

  typedef struct {
    logic [2:0] st;
    logic [5:0] idx;
    logic       roi, lst;
  } outcome_t;

  typedef struct {
    box_t       b;
    logic       chk;
    logic [2:0] st;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready;
  logic [1:0] command = CMD_LOAD;
  logic [9:0] min_x = 0, min_y = 0, max_x = 0, max_y = 0;
  logic last_in_frame = 0;
  logic out_valid, out_ready = 0;
  logic [2:0] status;
  logic [5:0] track_index;
  logic in_roi, last;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = REG_TOL;
  logic [9:0] cfg_data = 0;

  blob_track_matcher uut (.*);

  always #4 clk = ~clk;

  // predictor state
  logic [9:0] tol, rminx, rminy, rmaxx, rmaxy;
  logic [9:0] fx [64], fy [64], hx [64], hy [64];
  logic hist [64], act [64], seen [64];
  logic [20:0] bestd [64];
  int ntrk, nfb;
  logic [9:0] cx [32], cy [32];
  logic roib [32];
  outcome_t pending_q [$];

  int errors = 0, cycles = 0;
  int send_idle = 20, recv_idle = 56;
  logic dir_chk = 0;
  logic [2:0] dir_st;

  function automatic logic [20:0] sqd(logic [9:0] ax, ay, bx, by);
    int dx, dy;
    dx = ax > bx ? ax - bx : bx - ax;
    dy = ay > by ? ay - by : by - ay;
    return 21'(dx * dx + dy * dy);
  endfunction

  task automatic clear_seen();
    for (int i = 0; i < ntrk; i++) begin
      seen[i] = 0;
      bestd[i] = tol * tol;
    end
  endtask

  task automatic match_frame();
    logic [20:0] t2, bst, d, e;
    int cand [32];
    logic vis [32];
    int m, old;
    outcome_t o;
    t2 = tol * tol;
    old = ntrk;
    clear_seen();
    for (int j = 0; j < nfb; j++) begin
      bst = t2; m = -1; vis[j] = 1;
      for (int i = 0; i < old; i++) begin
        if (!act[i]) continue;
        d = sqd(cx[j], cy[j], fx[i], fy[i]);
        if (hist[i]) begin
          e = sqd(cx[j], cy[j], hx[i], hy[i]);
          if (e < d) d = e;
        end
        if (d > t2) continue;
        if (d > bestd[i]) begin
          vis[j] = 0;
          continue;
        end
        if (bst > d) begin
          bst = d; m = i; bestd[i] = d;
        end
      end
      cand[j] = m;
      if (m >= 0) seen[m] = 1;
    end
    for (int j = 0; j < nfb; j++) begin
      o.roi = roib[j]; o.lst = (j + 1 == nfb); o.idx = 0;
      if (!vis[j]) o.st = ST_DROP;
      else if (cand[j] >= 0) begin
        hx[cand[j]] = cx[j]; hy[cand[j]] = cy[j]; hist[cand[j]] = 1;
        o.st = ST_MATCH; o.idx = 6'(cand[j]);
      end else if (ntrk < 64) begin
        fx[ntrk] = cx[j]; fy[ntrk] = cy[j]; hist[ntrk] = 0;
        act[ntrk] = 1; seen[ntrk] = 1; bestd[ntrk] = t2;
        o.st = ST_NEW; o.idx = 6'(ntrk); ntrk++;
      end else o.st = ST_FULL;
      pending_q = {pending_q, o};
    end
    nfb = 0;
  endtask

  task automatic predict_box(box_t b);
    outcome_t o;
    if (b.cmd == CMD_LOAD) begin
      if (nfb < 32) begin
        cx[nfb] = 10'((11'(b.mnx) + b.mxx) >> 1);
        cy[nfb] = 10'((11'(b.mny) + b.mxy) >> 1);
        roib[nfb] = !(b.mnx > rmaxx || rminx > b.mxx ||
                      b.mny > rmaxy || rminy > b.mxy);
        nfb++;
      end
      if (b.lif) match_frame();
    end else if (b.cmd == CMD_AGE) begin
      for (int i = 0; i < ntrk; i++) if (!seen[i]) act[i] = 0;
    end else if (b.cmd == CMD_EMPTY) begin
      nfb = 0;
      clear_seen();
      o.st = ST_EMPTY; o.idx = 0; o.roi = 0; o.lst = 1;
      pending_q = {pending_q, o};
    end
  endtask

  task automatic send_box(box_t b);
    cfg_valid <= 0;
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    in_valid <= 1; command <= b.cmd; min_x <= b.mnx; min_y <= b.mny;
    max_x <= b.mxx; max_y <= b.mxy; last_in_frame <= b.lif;
    do @(posedge clk); while (!in_ready);
    predict_box(b);
  endtask

  task automatic write_reg(logic [2:0] idx, int v);
    in_valid <= 0;
    cfg_valid <= 1; cfg_index <= idx; cfg_data <= 10'(v);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_TOL:  tol = 10'(v);
      REG_MINX: rminx = 10'(v);
      REG_MINY: rminy = 10'(v);
      REG_MAXX: rmaxx = 10'(v);
      REG_MAXY: rmaxy = 10'(v);
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    cfg_valid <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // receiver and checker
  always @(posedge clk) begin
    outcome_t x;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        errors = errors + 1;
        if (errors <= 10) $display("unexpected transfer st=%0d", status);
      end else begin
        x = pending_q.pop_front();
        if (dir_chk && status != dir_st) begin
          errors = errors + 1;
          if (errors <= 10) $display("table status exp %0d got %0d", dir_st, status);
        end
        if (status !== x.st || track_index !== x.idx || in_roi !== x.roi ||
            last !== x.lst) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("exp st=%0d idx=%0d roi=%0d last=%0d got %0d %0d %0d %0d",
                     x.st, x.idx, x.roi, x.lst, status, track_index, in_roi, last);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  always @(posedge clk)
    if (cycles > 2000000) begin
      $display("blob_track_matcher test failed");
      $finish;
    end

  function automatic box_t mk(int c, int a, b2, c2, d, int l);
    box_t r;
    r.cmd = 2'(c); r.mnx = 10'(a); r.mny = 10'(b2); r.mxx = 10'(c2); r.mxy = 10'(d);
    r.lif = 1'(l);
    return r;
  endfunction

  function automatic box_t rnd_box(logic l);
    int x, y, w, h;
    x = $urandom_range(1023); y = $urandom_range(1023);
    if ($urandom_range(9) == 0) return mk(CMD_LOAD, $urandom_range(1023),
        $urandom_range(1023), $urandom_range(1023), $urandom_range(1023), l);
    // keep blobs near earlier centers so matches happen
    if (nfb == 0 && ntrk > 0 && $urandom_range(3) != 0) begin
      w = $urandom_range(ntrk - 1);
      x = fx[w] + $urandom_range(20); y = fy[w] + $urandom_range(20);
      if (x > 1000) x = 1000;
      if (y > 1000) y = 1000;
    end
    w = $urandom_range(23); h = $urandom_range(23);
    return mk(CMD_LOAD, x > w ? x - w : 0, y > h ? y - h : 0,
              x + w > 1023 ? 1023 : x + w, y + h > 1023 ? 1023 : y + h, l);
  endfunction

  row_t dir_rows [$];

  initial begin
    row_t r;
    int n;
    tol = 50; rminx = 0; rminy = 0; rmaxx = 1023; rmaxy = 1023;
    ntrk = 0; nfb = 0;
    for (int i = 0; i < 64; i++) begin
      hist[i] = 0; act[i] = 0; seen[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    r.chk = 1; r.st = ST_EMPTY; r.b = mk(CMD_EMPTY, 0, 0, 0, 0, 0); dir_rows = {dir_rows, r};
    r.chk = 1; r.st = ST_NEW; r.b = mk(CMD_LOAD, 0, 0, 0, 0, 1); dir_rows = {dir_rows, r};
    r.chk = 0; r.b = mk(CMD_LOAD, 1023, 1023, 1023, 1023, 0); dir_rows = {dir_rows, r};
    r.b = mk(CMD_LOAD, 2, 2, 4, 4, 0); dir_rows = {dir_rows, r};
    r.b = mk(CMD_LOAD, 4, 4, 2, 2, 1); dir_rows = {dir_rows, r};
    r.b = mk(CMD_LOAD, 10, 10, 12, 12, 0); dir_rows = {dir_rows, r};
    r.b = mk(CMD_LOAD, 1000, 1000, 1023, 1023, 1); dir_rows = {dir_rows, r};
    r.b = mk(CMD_AGE, 0, 0, 0, 0, 0); dir_rows = {dir_rows, r};
    r.b = mk(CMD_UNUSED, 5, 5, 5, 5, 1); dir_rows = {dir_rows, r};
    r.b = mk(CMD_LOAD, 500, 500, 520, 520, 1); dir_rows = {dir_rows, r};
    r.b = mk(CMD_AGE, 0, 0, 0, 0, 0); dir_rows = {dir_rows, r};
    r.b = mk(CMD_LOAD, 2, 2, 2, 2, 1); dir_rows = {dir_rows, r};
    foreach (dir_rows[k]) begin
      dir_chk = dir_rows[k].chk; dir_st = dir_rows[k].st;
      send_box(dir_rows[k].b);
      if (dir_chk) drain();
    end
    drain();
    dir_chk = 0;

    // region of interest and tolerance extremes
    write_reg(REG_MINX, 100); write_reg(REG_MINY, 100);
    write_reg(REG_MAXX, 200); write_reg(REG_MAXY, 200);
    write_reg(REG_TOL, 0);
    send_box(mk(CMD_LOAD, 0, 0, 99, 99, 0));
    send_box(mk(CMD_LOAD, 201, 150, 300, 160, 0));
    send_box(mk(CMD_LOAD, 150, 0, 160, 100, 0));
    send_box(mk(CMD_LOAD, 2, 2, 2, 2, 1));
    drain();
    write_reg(REG_TOL, 1023);
    send_box(mk(CMD_LOAD, 0, 1023, 1023, 0, 1));
    drain();
    write_reg(REG_MINX, 1023); write_reg(REG_MINY, 1023);
    // 33 boxes: overflow, last flag on the ignored one
    for (int k = 0; k < 33; k++) send_box(rnd_box(k == 32));
    drain();
    write_reg(REG_MINX, 0); write_reg(REG_MINY, 0);
    write_reg(REG_MAXX, 1023); write_reg(REG_MAXY, 1023);
    write_reg(REG_TOL, 30);
    send_box(mk(CMD_AGE, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin send_idle = 56; recv_idle = 20; end
      if (ph == 2) begin send_idle = 0; recv_idle = 0; end
      drain();
      write_reg(REG_TOL, $urandom_range(1, 80));
      write_reg(REG_MINX, $urandom_range(400)); write_reg(REG_MAXX, $urandom_range(600, 1023));
      n = 0;
      while (n < 16) begin
        case ($urandom_range(9))
          0: send_box(mk(CMD_AGE, 0, 0, 0, 0, 0));
          1: send_box(mk(CMD_EMPTY, 0, 0, 0, 0, 0));
          2: send_box(mk(CMD_UNUSED, $urandom_range(1023), 0, 0, 0, $urandom_range(1)));
          default: begin
            int k;
            k = $urandom_range(1, 5);
            for (int q = 0; q < k; q++) send_box(rnd_box(q == k - 1));
            n = n + k;
          end
        endcase
        n = n + 1;
      end
    end
    drain();
    if (errors == 0) $display("blob_track_matcher test passed");
    else $display("blob_track_matcher test failed");
    $finish;
  end
endmodule

// File: sim.f
+incdir+sv
sv/btm_pkg.sv
sv/btm_cell.sv
sv/btm_dist.sv
sv/blob_track_matcher.sv
tb/blob_track_matcher_tb.sv
